FILE: hdl/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 64;

  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_LINE = 2'd1,
    OP_FILL = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PEN_ERASE  = 2'd0,
    PEN_SET    = 2'd1,
    PEN_INVERT = 2'd2,
    PEN_OTHER  = 2'd3
  } pen_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_RDWAIT,
    ST_WR,
    ST_NEXT,
    ST_FILL,
    ST_READ,
    ST_READWAIT
  } state_t;
endpackage

FILE: hdl/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// Monochrome page framebuffer draw engine.
// Command port: a word is taken when start is high and busy is low. Fields:
// in_op (plot, line, fill, read), start/end coordinates, in_pen, in_page_sel.
// Only a read gives a result: out_page_byte with out_valid high for one cycle.
// The receiver cannot stall; a result is simply presented once.
// The frame store is one single-port memory of COLUMNS*ceil(ROWS/8) bytes, column
// major (column*pages+page). Each pixel is a read-modify-write on that port.
// States per word after the accept, all bound by the one memory port:
//   plot: ST_NEXT, ST_RD, ST_RDWAIT, ST_WR (no ST_RDWAIT off screen); read: ST_READ,
//   ST_READWAIT, result in the cycle after; fill (set or erase pen only, other pens
//   do nothing): ST_FILL over every byte (one byte a cycle); line: per point as plot,
//   plus for sloped lines ST_DIV for the restoring divider (one quotient bit a cycle).
// After reset a clearing pass writes zero to every byte, with busy high
// throughout.
// Line y for sloped lines: y_start + dy*(col-x_start)/dx, truncated toward
// zero; the product is formed once per point, then divided by |dx|.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_x_start,
  input  logic [7:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic [1:0] in_pen,
  input  logic [2:0] in_page_sel,
  output logic       out_valid,
  output logic [7:0] out_page_byte
);
  localparam int PAGES = (ROWS + 7) / 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;

  // frame store
  logic [7:0]    mem [DEPTH];
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  // command registers
  pen_t        pen_r;
  logic [8:0]  lo_r, hi_r, c_r;      // loop bounds / counter (9 bits for 255+1)
  logic        mode_r;               // 1: column sweep, row fixed unless sloped; else row sweep
  logic        slope_r;
  logic signed [9:0] xa_r, ya_r, dy_r;
  logic [7:0]  adx_r;
  logic        neg_r;                // sign of product/dx
  logic [8:0]  px_r, py_r;           // current pixel
  logic [AW:0] cnt_r;

  // divider: 16-bit magnitude by 8-bit divisor
  logic [15:0] dq_r;
  logic [8:0]  drem_r;
  logic [4:0]  dcnt_r;

  logic [AW:0] cnt_nxt;
  logic [8:0]  c_nxt;

  // product |dy*(c-xa)|, at most 255*255
  logic signed [9:0]  cdiff;
  logic signed [19:0] prod;
  logic [15:0] pmag;
  logic [8:0]  dtrial;
  logic signed [9:0] yq;

  assign cdiff = $signed({1'b0, c_r}) - xa_r;
  assign prod  = dy_r * cdiff;
  assign pmag  = prod[19] ? 16'(-prod) : 16'(prod);
  assign dtrial = {drem_r[7:0], dq_r[15]} - {1'b0, adx_r};
  assign yq = neg_r ? ya_r - $signed({2'b00, dq_r[7:0]}) : ya_r + $signed({2'b00, dq_r[7:0]});

  logic onscr;
  assign onscr = (px_r < 9'(COLUMNS)) && (py_r < 9'(ROWS));

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(32'(px_r) * PAGES + 32'(py_r[8:3]));

  logic [7:0] bitm;
  assign bitm = 8'(1) << py_r[2:0];

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    addr = pix_addr;
    wdata = 8'h00;
    cnt_nxt = cnt_r;
    c_nxt = c_r;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        addr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        cnt_nxt = '0;
        if (start) begin
          unique case (op_t'(in_op))
            OP_PLOT, OP_LINE: state_nxt = ST_NEXT;
            OP_FILL: state_nxt = (in_pen == PEN_SET || in_pen == PEN_ERASE) ? ST_FILL : ST_IDLE;
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NEXT: begin
        // point at c_r set up; pixel coords registered in same cycle
        state_nxt = slope_r ? ST_DIV : ST_RD;
      end
      ST_DIV: begin
        if (dcnt_r == 5'd16) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = onscr ? ST_RDWAIT : ST_WR;
      end
      ST_RDWAIT: state_nxt = ST_WR;
      ST_WR: begin
        if (onscr) begin
          we = 1'b1;
          case (pen_r)
            PEN_SET:    wdata = rdata_r | bitm;
            PEN_INVERT: wdata = rdata_r ^ bitm;
            default:    wdata = rdata_r & ~bitm;
          endcase
        end
        c_nxt = c_r + 1'b1;
        state_nxt = (c_r == hi_r) ? ST_IDLE : ST_NEXT;
      end
      ST_FILL: begin
        we = 1'b1;
        addr = cnt_r[AW-1:0];
        wdata = (pen_r == PEN_SET) ? 8'hff : 8'h00;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        addr = pix_addr;
        state_nxt = ST_READWAIT;
      end
      ST_READWAIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid <= (state_r == ST_READWAIT);
    end
  end

  logic rd_ok_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_READWAIT)
      out_page_byte <= rd_ok_r ? rdata_r : 8'h00;
    unique case (state_r)
      ST_IDLE: if (start) begin
        pen_r  <= pen_t'(in_pen);
        xa_r   <= $signed({2'b00, in_x_start});
        ya_r   <= $signed({2'b00, in_y_start});
        dy_r   <= $signed({2'b00, in_y_end}) - $signed({2'b00, in_y_start});
        adx_r  <= (in_x_end > in_x_start) ? in_x_end - in_x_start : in_x_start - in_x_end;
        if (in_op == OP_READ) begin
          px_r <= {1'b0, in_x_start};
          py_r <= {in_page_sel, 3'b000} + 9'd0;
          rd_ok_r <= (in_x_start < 9'(COLUMNS)) && (32'(in_page_sel) < PAGES);
        end
        if (in_op == OP_PLOT || in_y_start == in_y_end) begin
          mode_r <= 1'b1; slope_r <= 1'b0;
          lo_r <= (in_op == OP_PLOT) ? {1'b0, in_x_start}
                  : {1'b0, (in_x_start < in_x_end) ? in_x_start : in_x_end};
          hi_r <= (in_op == OP_PLOT) ? {1'b0, in_x_start}
                  : {1'b0, (in_x_start < in_x_end) ? in_x_end : in_x_start};
          c_r  <= (in_op == OP_PLOT) ? {1'b0, in_x_start}
                  : {1'b0, (in_x_start < in_x_end) ? in_x_start : in_x_end};
        end else if (in_x_start == in_x_end) begin
          mode_r <= 1'b0; slope_r <= 1'b0;
          lo_r <= {1'b0, (in_y_start < in_y_end) ? in_y_start : in_y_end};
          hi_r <= {1'b0, (in_y_start < in_y_end) ? in_y_end : in_y_start};
          c_r  <= {1'b0, (in_y_start < in_y_end) ? in_y_start : in_y_end};
        end else begin
          mode_r <= 1'b1; slope_r <= 1'b1;
          lo_r <= {1'b0, (in_x_start < in_x_end) ? in_x_start : in_x_end};
          hi_r <= {1'b0, (in_x_start < in_x_end) ? in_x_end : in_x_start};
          c_r  <= {1'b0, (in_x_start < in_x_end) ? in_x_start : in_x_end};
        end
      end
      ST_NEXT: begin
        px_r <= mode_r ? c_r : 9'(xa_r);
        py_r <= mode_r ? 9'(ya_r) : c_r;
        dq_r <= pmag;
        drem_r <= '0;
        dcnt_r <= '0;
        // sign of quotient: sign(prod) xor sign(dx), dx sign = (x_end<x_start)
        neg_r <= prod[19] ^ (lo_r != 9'(xa_r));
      end
      ST_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r != 5'd16) begin
          if (!dtrial[8]) begin
            drem_r <= dtrial;
            dq_r <= {dq_r[14:0], 1'b1};
          end else begin
            drem_r <= {drem_r[7:0], dq_r[15]};
            dq_r <= {dq_r[14:0], 1'b0};
          end
        end else begin
          py_r <= yq[9] ? 9'h1ff : yq[8:0];
        end
      end
      ST_WR: c_r <= c_nxt;
      default: ;
    endcase
  end

  // assertions
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> busy) else $error("idle during clear");
  a_out_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_READWAIT)) else $error("stray result");
  a_wr_onscr: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == ST_WR) |-> onscr) else $error("off-screen write");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> dcnt_r <= 5'd16) else $error("divider overrun");
endmodule
